>>> hw/rtl/otof_pkg.sv
package otof_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    typedef enum logic [1:0] {
        CMD_APPEND        = 2'd0,
        CMD_REMOVE_OLDEST = 2'd1,
        CMD_DELETE        = 2'd2,
        CMD_QUERY         = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_MUL,
        S_SHIFT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] order_id;
        logic [31:0] arrival_time;
        logic [19:0] unit_price;
        logic [11:0] quantity;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_id;
        logic [31:0] found_time;
        logic [19:0] found_price;
        logic [11:0] found_quantity;
        logic [31:0] entry_value;
        logic [4:0]  entry_count;
        logic [15:0] total_quantity;
        logic [35:0] total_value;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arr_time;
        logic [19:0] price;
        logic [11:0] qty;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic append_wr;
        logic scan;
        logic mul_best;
        logic shift_init;
        logic shift;
        logic fin;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       scan_done;
        logic       found;
        logic       shift_done;
        logic       out_free;
    } t_sts;

endpackage

>>> hw/rtl/otof_ctrl.sv
module otof_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  otof_pkg::t_sts i_sts,
    output otof_pkg::t_ctl o_ctl
);
    import otof_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sts.cmd == CMD_APPEND) ? S_APPEND : S_SCAN;
                end
            end
            S_APPEND: n_state = S_FIN;
            S_SCAN: begin
                if (i_sts.empty) begin
                    n_state = S_FIN;
                end else if (i_sts.scan_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.found && i_sts.cmd != CMD_QUERY) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_ctl.load_in = i_in_valid;
            end
            S_APPEND: o_ctl.append_wr = 1'b1;
            S_SCAN:   o_ctl.scan      = 1'b1;
            S_MUL: begin
                o_ctl.mul_best   = 1'b1;
                o_ctl.shift_init = i_sts.found && i_sts.cmd != CMD_QUERY;
            end
            S_SHIFT:  o_ctl.shift = 1'b1;
            S_FIN:    o_ctl.fin   = i_sts.out_free;
            default:  o_ctl       = '0;
        endcase
    end

endmodule

>>> hw/rtl/otof_dp.sv
module otof_dp #(
    parameter int TABLE_DEPTH = otof_pkg::DEF_TABLE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  otof_pkg::t_in  i_in_data,
    input  otof_pkg::t_ctl i_ctl,
    output otof_pkg::t_sts o_sts,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output otof_pkg::t_out o_out_data
);
    import otof_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_entry r_mem [TABLE_DEPTH];

    t_in           r_in;
    t_entry        r_rd_q;
    logic [AW-1:0] r_q_idx;
    logic          r_q_vld;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_count;
    logic [15:0]   r_tq;
    logic [35:0]   r_tv;
    t_entry        r_best;
    logic [AW-1:0] r_best_idx;
    logic          r_found;
    logic [31:0]   r_prod;
    t_out          r_out;
    logic          r_out_vld;

    logic [CW-1:0] n_count;
    logic [15:0]   n_tq;
    logic [35:0]   n_tv;

    logic          full;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        in_entry;
    logic          take;
    logic [19:0]   mul_a;
    logic [11:0]   mul_b;
    logic          out_take;
    t_status       status_c;
    logic          ok_c;

    assign full     = (r_count == CW'(TABLE_DEPTH));
    assign rd_en    = (i_ctl.scan || i_ctl.shift) && (r_ptr < r_count);
    assign in_entry = '{id: r_in.order_id, arr_time: r_in.arrival_time,
                        price: r_in.unit_price, qty: r_in.quantity};

    // single write port: append at the tail, or shift one place down
    assign wr_en   = (i_ctl.append_wr && !full) || (i_ctl.shift && r_q_vld);
    assign wr_addr = i_ctl.append_wr ? r_count[AW-1:0] : r_q_idx - AW'(1);
    assign wr_data = i_ctl.append_wr ? in_entry : r_rd_q;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_q <= r_mem[r_ptr[AW-1:0]];
        end
        r_q_idx <= r_ptr[AW-1:0];
    end

    // scan compare: oldest time (first wins ties) or first id match
    always_comb begin
        take = 1'b0;
        if (i_ctl.scan && r_q_vld) begin
            if (r_in.cmd == CMD_REMOVE_OLDEST) begin
                take = !r_found || (r_rd_q.arr_time < r_best.arr_time);
            end else begin
                take = !r_found && (r_rd_q.id == r_in.order_id);
            end
        end
    end

    assign mul_a = i_ctl.append_wr ? r_in.unit_price : r_best.price;
    assign mul_b = i_ctl.append_wr ? r_in.quantity   : r_best.qty;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_in <= i_in_data;
        end
        if (take) begin
            r_best     <= r_rd_q;
            r_best_idx <= r_q_idx;
        end
        if (i_ctl.append_wr || i_ctl.mul_best) begin
            r_prod <= 32'(mul_a * mul_b);
        end
    end

    always_comb begin
        if (r_in.cmd == CMD_APPEND) begin
            status_c = full ? ST_FULL : ST_OK;
        end else if (r_in.cmd == CMD_REMOVE_OLDEST) begin
            status_c = r_found ? ST_OK : ST_EMPTY;
        end else begin
            status_c = r_found ? ST_OK : ST_NOT_FOUND;
        end
        ok_c = (status_c == ST_OK);
    end

    always_comb begin
        n_count = r_count;
        n_tq    = r_tq;
        n_tv    = r_tv;
        if (ok_c && r_in.cmd == CMD_APPEND) begin
            n_count = r_count + CW'(1);
            n_tq    = r_tq + 16'(r_in.quantity);
            n_tv    = r_tv + 36'(r_prod);
        end else if (ok_c && r_in.cmd != CMD_QUERY) begin
            n_count = r_count - CW'(1);
            n_tq    = r_tq - 16'(r_best.qty);
            n_tv    = r_tv - 36'(r_prod);
        end
    end

    assign out_take = r_out_vld && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            r_out.status         <= status_c;
            r_out.entry_count    <= 5'(n_count);
            r_out.total_quantity <= n_tq;
            r_out.total_value    <= n_tv;
            if (ok_c && r_in.cmd != CMD_APPEND) begin
                r_out.found_id       <= r_best.id;
                r_out.found_time     <= r_best.arr_time;
                r_out.found_price    <= r_best.price;
                r_out.found_quantity <= r_best.qty;
                r_out.entry_value    <= r_prod;
            end else begin
                r_out.found_id       <= '0;
                r_out.found_time     <= '0;
                r_out.found_price    <= '0;
                r_out.found_quantity <= '0;
                r_out.entry_value    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld   <= 1'b0;
            r_ptr     <= '0;
            r_count   <= '0;
            r_tq      <= '0;
            r_tv      <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_q_vld <= rd_en;
            if (i_ctl.load_in) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
            end else if (i_ctl.shift_init) begin
                r_ptr <= CW'(r_best_idx) + CW'(1);
            end else if (rd_en) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (i_ctl.fin) begin
                r_count <= n_count;
                r_tq    <= n_tq;
                r_tv    <= n_tv;
            end
            if (i_ctl.fin) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.cmd        = i_ctl.load_in ? i_in_data.cmd : r_in.cmd;
        o_sts.empty      = (r_count == '0);
        o_sts.scan_done  = r_q_vld && (CW'(r_q_idx) == r_count - CW'(1));
        o_sts.found      = r_found;
        o_sts.shift_done = !(r_ptr < r_count) && !r_q_vld;
        o_sts.out_free   = !r_out_vld || !i_out_stall;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/order_table_oldest_first.sv
// Order of work: an append writes the tail directly, every other command scans the N entries
//   held (ending at once on an empty table), and a removal then also moves each later entry
//   down one place.
// Throughput: one command at a time, the next taken the cycle after its result registers;
//   scan and shift handle one entry per cycle (one read and one write port on the entries).
// Reset (i_rst_n low, synchronous): table empty, totals zero, no result pending, entries kept.
module order_table_oldest_first #(
    parameter int TABLE_DEPTH = otof_pkg::DEF_TABLE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // command channel
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  otof_pkg::t_in  i_in_data,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output otof_pkg::t_out o_out_data
);
    import otof_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // Sequencer: idle -> (append | scan [-> multiply [-> shift]]) -> finish.
    // The finish step waits only on the result register, so a new command
    // transfer can be taken while the previous result is still held.
    otof_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // Entry memory, scan compare, one 20x12 multiplier, running totals
    // and the result register.
    otof_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
